// ----- design/prl_pkg.sv -----
package prl_pkg;

  localparam int unsigned NumClients = 64;
  localparam int unsigned IdxW       = $clog2(NumClients);
  localparam int unsigned MaxLimit   = 16;
  localparam int unsigned SlotW      = $clog2(MaxLimit);
  localparam int unsigned LimW       = $clog2(MaxLimit + 1);
  localparam int unsigned MaxEvents  = 2048;
  localparam int unsigned EvW        = $clog2(MaxEvents + 1);
  localparam int unsigned KeyW       = 64;
  localparam int unsigned TimeW      = 40;
  localparam int unsigned FuncW      = 3;
  localparam int unsigned SecsW      = 16;
  localparam int unsigned WindowMs   = 60000;
  localparam int unsigned SweepMs    = 600000;
  localparam int unsigned IdleMs     = 900000;
  localparam int unsigned MsPerSec   = 1000;
  localparam int unsigned LogAw      = 1 + IdxW + SlotW;

  localparam logic [FuncW-1:0] FN_QUERY   = 3'd0;
  localparam logic [FuncW-1:0] FN_REQUEST = 3'd1;
  localparam logic [FuncW-1:0] FN_DENIAL  = 3'd2;
  localparam logic [FuncW-1:0] FN_UNBLOCK = 3'd3;
  localparam logic [FuncW-1:0] FN_CLEAR   = 3'd4;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_PASS_INIT,
    CMD_SCAN,
    CMD_QUERY,
    CMD_REMOVE,
    CMD_SET_V,
    CMD_NOROOM,
    CMD_CREATE,
    CMD_TRIM_RD,
    CMD_POP,
    CMD_PUSH,
    CMD_BLOCK,
    CMD_WRITE,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic sweep_en;
  } ctl_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             lim_zero;
    logic             sweep_due;
    logic             pass_last;
    logic             found;
    logic             free_found;
    logic             fill_zero;
    logic             expired;
    logic             exceeded;
    logic             budget_spent;
    logic             block_now;
    logic             out_free;
  } status_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] last;
    logic [TimeW-1:0] deadline;
    logic [LimW-1:0]  rfill;
    logic [SlotW-1:0] rhead;
    logic [LimW-1:0]  dfill;
    logic [SlotW-1:0] dhead;
  } meta_t;

  function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

  function automatic logic [EvW-1:0] ev_drop(logic [EvW-1:0] ev, logic [EvW-1:0] n);
    return (ev >= n) ? ev - n : '0;
  endfunction

endpackage

// ----- design/prl_in_if.sv -----
interface prl_in_if;
  logic                         valid;
  logic                         ready;
  logic [prl_pkg::FuncW-1:0]    func;
  logic [prl_pkg::KeyW-1:0]     client_key;
  logic [prl_pkg::TimeW-1:0]    now_ms;
  logic [prl_pkg::LimW-1:0]     limit;
  logic [prl_pkg::SecsW-1:0]    block_seconds;

  modport source (output valid, func, client_key, now_ms, limit, block_seconds, input ready);
  modport sink (input valid, func, client_key, now_ms, limit, block_seconds, output ready);
endinterface

// ----- design/prl_out_if.sv -----
interface prl_out_if;
  logic valid;
  logic ready;
  logic verdict;
  logic no_room;

  modport source (output valid, verdict, no_room, input ready);
  modport sink (input valid, verdict, no_room, output ready);
endinterface

// ----- design/prl_ram.sv -----
module prl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- design/prl_ctrl.sv -----
module prl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  prl_pkg::status_t st_i,
  output prl_pkg::ctl_t    ctl_o
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_PASS   = 4'd2;
  localparam logic [3:0] S_AFTER  = 4'd3;
  localparam logic [3:0] S_TRIM   = 4'd4;
  localparam logic [3:0] S_TCHK   = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_BCHK   = 4'd7;
  localparam logic [3:0] S_WB     = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       forced_q, forced_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      forced_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      forced_q <= forced_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    forced_d       = forced_q;
    in_ready_o     = 1'b0;
    ctl_o.cmd      = prl_pkg::CMD_NONE;
    ctl_o.sweep_en = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.cmd = prl_pkg::CMD_LOAD;
          forced_d  = 1'b0;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        priority if (st_i.func == prl_pkg::FN_CLEAR) begin
          ctl_o.cmd = prl_pkg::CMD_CLEAR;
          state_d   = S_DONE;
        end else if (st_i.func <= prl_pkg::FN_UNBLOCK) begin
          ctl_o.cmd      = prl_pkg::CMD_PASS_INIT;
          ctl_o.sweep_en = (st_i.func != prl_pkg::FN_UNBLOCK) && st_i.sweep_due;
          state_d        = S_PASS;
        end else begin
          state_d = S_DONE;
        end
      end
      S_PASS: begin
        ctl_o.cmd = prl_pkg::CMD_SCAN;
        if (st_i.pass_last) state_d = S_AFTER;
      end
      S_AFTER: begin
        priority if (st_i.func == prl_pkg::FN_QUERY) begin
          ctl_o.cmd = prl_pkg::CMD_QUERY;
          state_d   = S_DONE;
        end else if (st_i.func == prl_pkg::FN_UNBLOCK) begin
          if (st_i.found) ctl_o.cmd = prl_pkg::CMD_REMOVE;
          state_d = S_DONE;
        end else if (st_i.func == prl_pkg::FN_REQUEST && st_i.lim_zero) begin
          ctl_o.cmd = prl_pkg::CMD_SET_V;
          state_d   = S_DONE;
        end else if (st_i.found) begin
          state_d = S_TRIM;
        end else if (st_i.free_found) begin
          ctl_o.cmd = prl_pkg::CMD_CREATE;
          state_d   = S_TRIM;
        end else if (!forced_q) begin
          // table full: forced sweep, then look for a free slot again
          ctl_o.cmd      = prl_pkg::CMD_PASS_INIT;
          ctl_o.sweep_en = 1'b1;
          forced_d       = 1'b1;
          state_d        = S_PASS;
        end else begin
          ctl_o.cmd = prl_pkg::CMD_NOROOM;
          state_d   = S_DONE;
        end
      end
      S_TRIM: begin
        if (st_i.fill_zero) begin
          state_d = S_DECIDE;
        end else begin
          ctl_o.cmd = prl_pkg::CMD_TRIM_RD;
          state_d   = S_TCHK;
        end
      end
      S_TCHK: begin
        if (st_i.expired) begin
          ctl_o.cmd = prl_pkg::CMD_POP;
          state_d   = S_TRIM;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st_i.func == prl_pkg::FN_REQUEST) begin
          ctl_o.cmd = st_i.exceeded ? prl_pkg::CMD_SET_V : prl_pkg::CMD_PUSH;
          state_d   = S_WB;
        end else if (st_i.budget_spent) begin
          ctl_o.cmd = prl_pkg::CMD_BLOCK;
          state_d   = S_WB;
        end else begin
          ctl_o.cmd = prl_pkg::CMD_PUSH;
          state_d   = S_BCHK;
        end
      end
      S_BCHK: begin
        if (st_i.block_now) ctl_o.cmd = prl_pkg::CMD_BLOCK;
        state_d = S_WB;
      end
      S_WB: begin
        ctl_o.cmd = prl_pkg::CMD_WRITE;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (st_i.out_free) begin
          ctl_o.cmd = prl_pkg::CMD_OUT;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// ----- design/prl_dp.sv -----
module prl_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  prl_pkg::ctl_t               ctl_i,
  input  logic [prl_pkg::FuncW-1:0]   func_i,
  input  logic [prl_pkg::KeyW-1:0]    key_i,
  input  logic [prl_pkg::TimeW-1:0]   now_i,
  input  logic [prl_pkg::LimW-1:0]    limit_i,
  input  logic [prl_pkg::SecsW-1:0]   secs_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        verdict_o,
  output logic                        no_room_o,
  output prl_pkg::status_t            st_o
);
  localparam int unsigned MetaW = $bits(prl_pkg::meta_t);
  localparam int unsigned MulW  = prl_pkg::SecsW + 10;

  logic [prl_pkg::FuncW-1:0]      func_q, func_d;
  logic [prl_pkg::KeyW-1:0]       key_q, key_d;
  logic [prl_pkg::TimeW-1:0]      now_q, now_d;
  logic [prl_pkg::LimW-1:0]       lim_q, lim_d;
  logic [prl_pkg::SecsW-1:0]      secs_q, secs_d;
  logic [prl_pkg::NumClients-1:0] valid_q, valid_d;
  logic [prl_pkg::EvW-1:0]        ev_q, ev_d;
  logic [prl_pkg::TimeW-1:0]      next_q, next_d;
  logic                           armed_q, armed_d;
  logic [prl_pkg::IdxW:0]         cnt_q, cnt_d;
  logic                           rd_vld_q, rd_vld_d;
  logic [prl_pkg::IdxW-1:0]       rd_idx_q, rd_idx_d;
  logic                           sweep_en_q, sweep_en_d;
  logic                           found_q, found_d;
  logic                           free_found_q, free_found_d;
  logic [prl_pkg::IdxW-1:0]       free_idx_q, free_idx_d;
  logic [prl_pkg::IdxW-1:0]       cur_idx_q, cur_idx_d;
  prl_pkg::meta_t                 cur_q, cur_d;
  logic                           res_v_q, res_v_d;
  logic                           res_nr_q, res_nr_d;
  logic                           out_vld_q, out_vld_d;
  logic                           out_v_q, out_v_d;
  logic                           out_nr_q, out_nr_d;

  logic                           meta_we, meta_re;
  logic [MetaW-1:0]               meta_rdata;
  prl_pkg::meta_t                 row;
  logic                           log_we, log_re;
  logic [prl_pkg::LogAw-1:0]      log_waddr, log_raddr;
  logic [prl_pkg::TimeW-1:0]      log_rdata;

  logic                           sel;
  logic [prl_pkg::LimW-1:0]       fill;
  logic [prl_pkg::SlotW-1:0]      head;
  logic                           row_v, stale;
  logic [prl_pkg::TimeW-1:0]      block_ms;

  assign row      = prl_pkg::meta_t'(meta_rdata);
  assign sel      = (func_q == prl_pkg::FN_DENIAL);
  assign fill     = sel ? cur_q.dfill : cur_q.rfill;
  assign head     = sel ? cur_q.dhead : cur_q.rhead;
  assign row_v    = valid_q[rd_idx_q];
  assign stale    = row_v && sweep_en_q
                    && ({1'b0, row.last} + (prl_pkg::TimeW+1)'(prl_pkg::IdleMs) < {1'b0, now_q})
                    && (row.deadline <= now_q);
  assign block_ms = prl_pkg::TimeW'(MulW'(secs_q) * MulW'(prl_pkg::MsPerSec));

  assign meta_re   = (ctl_i.cmd == prl_pkg::CMD_SCAN) && (cnt_q < (prl_pkg::IdxW+1)'(prl_pkg::NumClients));
  assign meta_we   = (ctl_i.cmd == prl_pkg::CMD_WRITE);
  assign log_re    = (ctl_i.cmd == prl_pkg::CMD_TRIM_RD);
  assign log_raddr = {sel, cur_idx_q, head};
  assign log_we    = (ctl_i.cmd == prl_pkg::CMD_PUSH) && (fill < prl_pkg::LimW'(prl_pkg::MaxLimit));
  assign log_waddr = {sel, cur_idx_q, head + fill[prl_pkg::SlotW-1:0]};

  prl_ram #(.Width(MetaW), .Depth(prl_pkg::NumClients)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (cur_idx_q),
    .wdata_i ({cur_q.key, now_q, cur_q.deadline, cur_q.rfill, cur_q.rhead,
               cur_q.dfill, cur_q.dhead}),
    .re_i    (meta_re),
    .raddr_i (cnt_q[prl_pkg::IdxW-1:0]),
    .rdata_o (meta_rdata)
  );

  // request log in the lower half, denial log in the upper half
  prl_ram #(.Width(prl_pkg::TimeW), .Depth(1 << prl_pkg::LogAw)) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (log_we),
    .waddr_i (log_waddr),
    .wdata_i (now_q),
    .re_i    (log_re),
    .raddr_i (log_raddr),
    .rdata_o (log_rdata)
  );

  always_comb begin
    func_d       = func_q;
    key_d        = key_q;
    now_d        = now_q;
    lim_d        = lim_q;
    secs_d       = secs_q;
    valid_d      = valid_q;
    ev_d         = ev_q;
    next_d       = next_q;
    armed_d      = armed_q;
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    sweep_en_d   = sweep_en_q;
    found_d      = found_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    cur_idx_d    = cur_idx_q;
    cur_d        = cur_q;
    res_v_d      = res_v_q;
    res_nr_d     = res_nr_q;
    out_vld_d    = out_vld_q && !out_ready_i;
    out_v_d      = out_v_q;
    out_nr_d     = out_nr_q;
    unique case (ctl_i.cmd)
      prl_pkg::CMD_LOAD: begin
        func_d   = func_i;
        key_d    = key_i;
        now_d    = now_i;
        lim_d    = (limit_i > prl_pkg::LimW'(prl_pkg::MaxLimit))
                   ? prl_pkg::LimW'(prl_pkg::MaxLimit) : limit_i;
        secs_d   = secs_i;
        res_v_d  = 1'b0;
        res_nr_d = 1'b0;
      end
      prl_pkg::CMD_CLEAR: begin
        valid_d = '0;
        ev_d    = '0;
        next_d  = '0;
        armed_d = 1'b0;
      end
      prl_pkg::CMD_PASS_INIT: begin
        cnt_d        = '0;
        sweep_en_d   = ctl_i.sweep_en;
        found_d      = 1'b0;
        free_found_d = 1'b0;
      end
      prl_pkg::CMD_SCAN: begin
        if (meta_re) begin
          cnt_d    = cnt_q + 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[prl_pkg::IdxW-1:0];
        end
        if (rd_vld_q) begin
          if (stale) begin
            valid_d[rd_idx_q] = 1'b0;
            ev_d = prl_pkg::ev_drop(ev_q, prl_pkg::EvW'(row.rfill) + prl_pkg::EvW'(row.dfill));
          end else if (row_v && row.key == key_q) begin
            found_d   = 1'b1;
            cur_idx_d = rd_idx_q;
            cur_d     = row;
          end
          if ((!row_v || stale) && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = rd_idx_q;
          end
          if (rd_idx_q == prl_pkg::IdxW'(prl_pkg::NumClients - 1) && sweep_en_q) begin
            next_d  = prl_pkg::sat_add(now_q, prl_pkg::TimeW'(prl_pkg::SweepMs));
            armed_d = 1'b1;
          end
        end
      end
      prl_pkg::CMD_QUERY: res_v_d = found_q && (cur_q.deadline > now_q);
      prl_pkg::CMD_REMOVE: begin
        valid_d[cur_idx_q] = 1'b0;
        ev_d    = prl_pkg::ev_drop(ev_q, prl_pkg::EvW'(cur_q.rfill) + prl_pkg::EvW'(cur_q.dfill));
        res_v_d = 1'b1;
      end
      prl_pkg::CMD_SET_V: res_v_d = 1'b1;
      prl_pkg::CMD_NOROOM: begin
        res_nr_d = 1'b1;
        res_v_d  = (func_q == prl_pkg::FN_REQUEST);
      end
      prl_pkg::CMD_CREATE: begin
        cur_idx_d           = free_idx_q;
        valid_d[free_idx_q] = 1'b1;
        cur_d               = '0;
        cur_d.key           = key_q;
        cur_d.last          = now_q;
      end
      prl_pkg::CMD_POP: begin
        ev_d = prl_pkg::ev_drop(ev_q, prl_pkg::EvW'(1));
        if (sel) begin
          cur_d.dhead = cur_q.dhead + 1'b1;
          cur_d.dfill = cur_q.dfill - 1'b1;
        end else begin
          cur_d.rhead = cur_q.rhead + 1'b1;
          cur_d.rfill = cur_q.rfill - 1'b1;
        end
      end
      prl_pkg::CMD_PUSH: begin
        if (log_we) begin
          ev_d = ev_q + 1'b1;
          if (sel) cur_d.dfill = cur_q.dfill + 1'b1;
          else     cur_d.rfill = cur_q.rfill + 1'b1;
        end
      end
      prl_pkg::CMD_BLOCK: begin
        cur_d.deadline = prl_pkg::sat_add(now_q, block_ms);
        ev_d           = prl_pkg::ev_drop(ev_q, prl_pkg::EvW'(cur_q.dfill));
        cur_d.dfill    = '0;
        cur_d.dhead    = '0;
        res_v_d        = 1'b1;
      end
      prl_pkg::CMD_OUT: begin
        out_vld_d = 1'b1;
        out_v_d   = res_v_q;
        out_nr_d  = res_nr_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      ev_q      <= '0;
      next_q    <= '0;
      armed_q   <= 1'b0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      ev_q      <= ev_d;
      next_q    <= next_d;
      armed_q   <= armed_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    key_q        <= key_d;
    now_q        <= now_d;
    lim_q        <= lim_d;
    secs_q       <= secs_d;
    rd_idx_q     <= rd_idx_d;
    sweep_en_q   <= sweep_en_d;
    found_q      <= found_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    cur_idx_q    <= cur_idx_d;
    cur_q        <= cur_d;
    res_v_q      <= res_v_d;
    res_nr_q     <= res_nr_d;
    out_v_q      <= out_v_d;
    out_nr_q     <= out_nr_d;
  end

  assign st_o.func         = func_q;
  assign st_o.lim_zero     = (lim_q == '0);
  assign st_o.sweep_due    = !armed_q || (now_q >= next_q);
  assign st_o.pass_last    = rd_vld_q && (rd_idx_q == prl_pkg::IdxW'(prl_pkg::NumClients - 1));
  assign st_o.found        = found_q;
  assign st_o.free_found   = free_found_q;
  assign st_o.fill_zero    = (fill == '0);
  assign st_o.expired      = ({1'b0, log_rdata} + (prl_pkg::TimeW+1)'(prl_pkg::WindowMs))
                             <= {1'b0, now_q};
  assign st_o.budget_spent = (ev_q >= prl_pkg::EvW'(prl_pkg::MaxEvents));
  assign st_o.exceeded     = (fill >= lim_q) || st_o.budget_spent;
  assign st_o.block_now    = (lim_q == '0) || (cur_q.dfill >= lim_q);
  assign st_o.out_free     = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign verdict_o   = out_v_q;
  assign no_room_o   = out_nr_q;

`ifndef SYNTH
  a_ev_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_q <= prl_pkg::EvW'(prl_pkg::MaxEvents))
    else $error("event total above budget");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.cmd == prl_pkg::CMD_CLEAR |=> valid_q == '0 && ev_q == '0 && !armed_q)
    else $error("clear left table state behind");
  a_create: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.cmd == prl_pkg::CMD_CREATE |=> valid_q[cur_idx_q] && cur_idx_q == $past(free_idx_q))
    else $error("new entry not valid");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.cmd == prl_pkg::CMD_OUT |=> out_vld_q)
    else $error("result beat lost");
`endif
endmodule

// ----- design/per_client_sliding_rate_limiter.sv -----
// per item: one walk of the 64-entry client table, a second walk when a forced sweep is needed;
// requests with a nonzero limit and denials then pop expired log times and write the entry back
// flow: one item at a time; clear and unknown codes skip the walk, and a new item is taken only
// once the last result is handed on; the table walk goes through the single metadata read port
// reset: control state cleared, table empty via per-entry valid flops, no clearing pass
module per_client_sliding_rate_limiter (
  input logic      clk_i,
  input logic      rst_ni,
  prl_in_if.sink   in_i,
  prl_out_if.source out_o
);
  prl_pkg::ctl_t    ctl;
  prl_pkg::status_t st;

  prl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .ctl_o      (ctl)
  );

  prl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .func_i      (in_i.func),
    .key_i       (in_i.client_key),
    .now_i       (in_i.now_ms),
    .limit_i     (in_i.limit),
    .secs_i      (in_i.block_seconds),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .verdict_o   (out_o.verdict),
    .no_room_o   (out_o.no_room),
    .st_o        (st)
  );
endmodule
